@@ src/random_cycle_builder_and_chaser_assert.svh @@
// Assertion macros used by the port-level checker.
`ifndef RANDOM_CYCLE_BUILDER_AND_CHASER_ASSERT_SVH
`define RANDOM_CYCLE_BUILDER_AND_CHASER_ASSERT_SVH

// Same-cycle implication, clocked on aclk, off during reset.
`define RCBC_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error("assertion failed");

// Next-cycle implication, clocked on aclk, off during reset.
`define RCBC_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

@@ src/rcbc_pkg.sv @@
// Package with constants and the generator step for the random cycle builder.
package rcbc_pkg;

    localparam int MAX_NODES_DEFAULT = 1024;
    localparam logic [63:0] GOLDEN_SEED = 64'h9e37_79b9_7f4a_7c15;
    localparam int XS_A = 13;
    localparam int XS_B = 7;
    localparam int XS_C = 17;

    localparam int IN_DATA_W  = 112;
    localparam int OUT_DATA_W = 16;
    localparam int NODE_CNT_W = 11;
    localparam int IDX_W      = 10;
    localparam int STEP_W     = 32;
    localparam int SEED_W     = 64;

    localparam logic MODE_BUILD = 1'b0;
    localparam logic MODE_CHASE = 1'b1;

    function automatic logic [63:0] xorshift(input logic [63:0] s);
        logic [63:0] x;
        x = s;
        x = x ^ (x << XS_A);
        x = x ^ (x >> XS_B);
        x = x ^ (x << XS_C);
        return x;
    endfunction

endpackage

@@ src/random_cycle_builder_and_chaser.sv @@
// Random single-cycle builder and pointer chaser, top level.
//
// Input channel s_*: one request per item. s_tuser is the mode (0 build, 1 chase).
// A build seeds a xorshift64 generator, shuffles the node order with Fisher-Yates
// and links the successor table into one cycle of the configured number of nodes.
// A chase walks that table from the start node for step_count hops, finding the
// period on the way and reducing the remaining hops modulo it.
// Result channel m_*: one result per request; m_tuser is bad_start.
// One request at a time: s_tready is high only while the sequencer idles.
// A build is paced by the bit-serial 64-bit remainder unit, run once per draw,
// and by the single read port of the order RAM.
// A chase walks hop by hop (S_CH, S_CHW) until the period is found, runs the
// remainder unit over the remaining hop count, then walks the rest (fewer than n).
// A bad start or a zero step count answers on the cycle after the request is taken.
// Reset: a clearing pass zeroes the successor RAM; s_tready stays low meanwhile.
// Config writes (cfg_wr_en) are taken at any time.
// When the receiver stalls, the result holds in m_tdata/m_tuser and no new
// request is taken until it is delivered.
module random_cycle_builder_and_chaser #(
    parameter int MAX_NODES = rcbc_pkg::MAX_NODES_DEFAULT
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                cfg_wr_en,
    input  logic [rcbc_pkg::NODE_CNT_W-1:0]     cfg_wr_data,
    input  logic                                s_tvalid,
    output logic                                s_tready,
    // [63:0] seed, [73:64] start node, [105:74] step_count, rest zero
    input  logic [rcbc_pkg::IN_DATA_W-1:0]      s_tdata,
    // [0] mode
    input  logic                                s_tuser,
    output logic                                m_tvalid,
    input  logic                                m_tready,
    // [9:0] end node, rest zero
    output logic [rcbc_pkg::OUT_DATA_W-1:0]     m_tdata,
    // [0] bad_start
    output logic                                m_tuser
);

    localparam int IW = (MAX_NODES > 1) ? $clog2(MAX_NODES) : 1;
    localparam int NW = $clog2(MAX_NODES + 1);

    localparam logic [4:0] S_CLR   = 5'd0;
    localparam logic [4:0] S_IDLE  = 5'd1;
    localparam logic [4:0] S_FILL  = 5'd2;
    localparam logic [4:0] S_DRAW  = 5'd3;
    localparam logic [4:0] S_MOD   = 5'd4;
    localparam logic [4:0] S_RDI   = 5'd5;
    localparam logic [4:0] S_RDJ   = 5'd6;
    localparam logic [4:0] S_WRI   = 5'd7;
    localparam logic [4:0] S_WRJ   = 5'd8;
    localparam logic [4:0] S_LK0   = 5'd9;
    localparam logic [4:0] S_LK1   = 5'd10;
    localparam logic [4:0] S_LK2   = 5'd11;
    localparam logic [4:0] S_LKE   = 5'd12;
    localparam logic [4:0] S_CH    = 5'd13;
    localparam logic [4:0] S_CHW   = 5'd14;
    localparam logic [4:0] S_TAIL  = 5'd15;
    localparam logic [4:0] S_TAILW = 5'd16;
    localparam logic [4:0] S_OUT   = 5'd17;

    logic [4:0]  state_reg, state_next;
    logic [IW-1:0] idx_reg, idx_next;
    logic [NW-1:0] n_reg, n_next;
    logic [63:0] rng_reg, rng_next;
    logic [63:0] div_reg, div_next;
    logic [6:0]  cnt_reg, cnt_next;
    logic [NW-1:0] dvs_reg, dvs_next;
    logic [NW-1:0] rem_reg, rem_next;
    logic [IW-1:0] oi_reg, oi_next;
    logic [IW-1:0] first_reg, first_next;
    logic [IW-1:0] prev_reg, prev_next;
    logic [IW-1:0] p_reg, p_next;
    logic [IW-1:0] saved_reg, saved_next;
    logic [31:0] t_reg, t_next;
    logic [31:0] steps_reg, steps_next;
    logic [NW:0] power_reg, power_next;
    logic [NW:0] lam_reg, lam_next;
    logic        mode_reg, mode_next;
    logic [rcbc_pkg::IDX_W-1:0] out_idx_reg, out_idx_next;
    logic        out_bad_reg, out_bad_next;
    logic [rcbc_pkg::NODE_CNT_W-1:0] nodes_cfg_reg;

    logic          ord_we, suc_we;
    logic [IW-1:0] ord_waddr, ord_wdata, ord_raddr, ord_rdata;
    logic [IW-1:0] suc_waddr, suc_wdata, suc_raddr, suc_rdata;

    logic [NW-1:0] n_eff;
    logic [63:0]   seed_in;
    logic [rcbc_pkg::IDX_W-1:0] start_in;
    logic [31:0]   steps_in;
    logic [NW:0]   rr;
    logic [NW-1:0] rem_step;
    logic [63:0]   x_draw;
    logic [31:0]   t_inc;

    assign seed_in  = s_tdata[63:0];
    assign start_in = s_tdata[73:64];
    assign steps_in = s_tdata[105:74];

    always_comb begin
        priority if (32'(nodes_cfg_reg) < 32'd2) begin
            n_eff = NW'(2);
        end else if (32'(nodes_cfg_reg) > 32'(MAX_NODES)) begin
            n_eff = NW'(MAX_NODES);
        end else begin
            n_eff = NW'(nodes_cfg_reg);
        end
    end

    // shared bit-serial remainder step
    assign rr       = {rem_reg, div_reg[63]};
    assign rem_step = (rr >= {1'b0, dvs_reg}) ? NW'(rr - {1'b0, dvs_reg}) : NW'(rr);
    assign x_draw   = rcbc_pkg::xorshift(rng_reg);
    assign t_inc    = t_reg + 32'd1;

    rcbc_ram #(.WIDTH(IW), .DEPTH(MAX_NODES)) u_order_ram (
        .aclk(aclk), .we(ord_we), .waddr(ord_waddr), .wdata(ord_wdata),
        .raddr(ord_raddr), .rdata(ord_rdata)
    );

    rcbc_ram #(.WIDTH(IW), .DEPTH(MAX_NODES)) u_succ_ram (
        .aclk(aclk), .we(suc_we), .waddr(suc_waddr), .wdata(suc_wdata),
        .raddr(suc_raddr), .rdata(suc_rdata)
    );

    always_comb begin
        ord_we    = 1'b0;
        ord_waddr = idx_reg;
        ord_wdata = idx_reg;
        ord_raddr = idx_reg;
        suc_we    = 1'b0;
        suc_waddr = idx_reg;
        suc_wdata = '0;
        suc_raddr = p_reg;
        unique case (state_reg)
            S_CLR: begin
                suc_we = 1'b1;
            end
            S_FILL: begin
                ord_we = 1'b1;
            end
            S_RDJ: begin
                ord_raddr = IW'(rem_reg);
            end
            S_WRI: begin
                ord_we    = 1'b1;
                ord_wdata = ord_rdata;
            end
            S_WRJ: begin
                ord_we    = 1'b1;
                ord_waddr = IW'(rem_reg);
                ord_wdata = oi_reg;
            end
            S_LK0: begin
                ord_raddr = '0;
            end
            S_LK1: begin
                ord_raddr = IW'(1);
            end
            S_LK2: begin
                ord_raddr = idx_reg + IW'(1);
                suc_we    = 1'b1;
                suc_waddr = prev_reg;
                suc_wdata = ord_rdata;
            end
            S_LKE: begin
                suc_we    = 1'b1;
                suc_waddr = prev_reg;
                suc_wdata = first_reg;
            end
            default: begin
            end
        endcase
    end

    always_comb begin
        state_next   = state_reg;
        idx_next     = idx_reg;
        n_next       = n_reg;
        rng_next     = rng_reg;
        div_next     = div_reg;
        cnt_next     = cnt_reg;
        dvs_next     = dvs_reg;
        rem_next     = rem_reg;
        oi_next      = oi_reg;
        first_next   = first_reg;
        prev_next    = prev_reg;
        p_next       = p_reg;
        saved_next   = saved_reg;
        t_next       = t_reg;
        steps_next   = steps_reg;
        power_next   = power_reg;
        lam_next     = lam_reg;
        mode_next    = mode_reg;
        out_idx_next = out_idx_reg;
        out_bad_next = out_bad_reg;
        unique case (state_reg)
            S_CLR: begin
                idx_next = idx_reg + IW'(1);
                if (32'(idx_reg) == MAX_NODES - 1) begin
                    idx_next   = '0;
                    state_next = S_IDLE;
                end
            end
            S_IDLE: begin
                if (s_tvalid) begin
                    mode_next = s_tuser;
                    if (s_tuser == rcbc_pkg::MODE_BUILD) begin
                        n_next     = n_eff;
                        rng_next   = (seed_in != 64'd0) ? seed_in : rcbc_pkg::GOLDEN_SEED;
                        idx_next   = '0;
                        state_next = S_FILL;
                    end else if (32'(start_in) >= 32'(n_eff)) begin
                        out_idx_next = start_in;
                        out_bad_next = 1'b1;
                        state_next   = S_OUT;
                    end else if (steps_in == 32'd0) begin
                        out_idx_next = start_in;
                        out_bad_next = 1'b0;
                        state_next   = S_OUT;
                    end else begin
                        p_next     = IW'(start_in);
                        saved_next = IW'(start_in);
                        t_next     = '0;
                        steps_next = steps_in;
                        power_next = (NW+1)'(1);
                        lam_next   = (NW+1)'(1);
                        state_next = S_CH;
                    end
                end
            end
            S_FILL: begin
                if (NW'(idx_reg) == n_reg - NW'(1)) begin
                    state_next = S_DRAW;
                end else begin
                    idx_next = idx_reg + IW'(1);
                end
            end
            S_DRAW: begin
                rng_next   = x_draw;
                div_next   = x_draw;
                cnt_next   = 7'd64;
                rem_next   = '0;
                dvs_next   = NW'(idx_reg) + NW'(1);
                state_next = S_MOD;
            end
            S_MOD: begin
                rem_next = rem_step;
                div_next = {div_reg[62:0], 1'b0};
                cnt_next = cnt_reg - 7'd1;
                if (cnt_reg == 7'd1) begin
                    state_next = (mode_reg == rcbc_pkg::MODE_BUILD) ? S_RDI : S_TAIL;
                end
            end
            S_RDI: begin
                state_next = S_RDJ;
            end
            S_RDJ: begin
                oi_next    = ord_rdata;
                state_next = S_WRI;
            end
            S_WRI: begin
                state_next = S_WRJ;
            end
            S_WRJ: begin
                if (idx_reg == IW'(1)) begin
                    state_next = S_LK0;
                end else begin
                    idx_next   = idx_reg - IW'(1);
                    state_next = S_DRAW;
                end
            end
            S_LK0: begin
                state_next = S_LK1;
            end
            S_LK1: begin
                first_next = ord_rdata;
                prev_next  = ord_rdata;
                idx_next   = IW'(1);
                state_next = S_LK2;
            end
            S_LK2: begin
                prev_next = ord_rdata;
                if (NW'(idx_reg) == n_reg - NW'(1)) begin
                    state_next = S_LKE;
                end else begin
                    idx_next = idx_reg + IW'(1);
                end
            end
            S_LKE: begin
                out_idx_next = '0;
                out_bad_next = 1'b0;
                state_next   = S_OUT;
            end
            S_CH: begin
                state_next = S_CHW;
            end
            S_CHW: begin
                p_next = suc_rdata;
                t_next = t_inc;
                priority if (t_inc == steps_reg) begin
                    out_idx_next = rcbc_pkg::IDX_W'(suc_rdata);
                    out_bad_next = 1'b0;
                    state_next   = S_OUT;
                end else if (suc_rdata == saved_reg) begin
                    // period found: reduce the remaining hops modulo it
                    dvs_next   = NW'(lam_reg);
                    div_next   = {steps_reg - t_inc, 32'd0};
                    cnt_next   = 7'd32;
                    rem_next   = '0;
                    state_next = S_MOD;
                end else if (lam_reg == power_reg) begin
                    saved_next = suc_rdata;
                    power_next = {power_reg[NW-1:0], 1'b0};
                    lam_next   = (NW+1)'(1);
                    state_next = S_CH;
                end else begin
                    lam_next   = lam_reg + (NW+1)'(1);
                    state_next = S_CH;
                end
            end
            S_TAIL: begin
                if (rem_reg == '0) begin
                    out_idx_next = rcbc_pkg::IDX_W'(p_reg);
                    out_bad_next = 1'b0;
                    state_next   = S_OUT;
                end else begin
                    state_next = S_TAILW;
                end
            end
            S_TAILW: begin
                p_next     = suc_rdata;
                rem_next   = rem_reg - NW'(1);
                state_next = S_TAIL;
            end
            S_OUT: begin
                if (m_tready) begin
                    state_next = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= S_CLR;
            idx_reg       <= '0;
            rng_reg       <= '0;
            nodes_cfg_reg <= rcbc_pkg::NODE_CNT_W'(1024);
        end else begin
            state_reg <= state_next;
            idx_reg   <= idx_next;
            rng_reg   <= rng_next;
            if (cfg_wr_en) begin
                nodes_cfg_reg <= cfg_wr_data;
            end
        end
    end

    always_ff @(posedge aclk) begin
        n_reg       <= n_next;
        div_reg     <= div_next;
        cnt_reg     <= cnt_next;
        dvs_reg     <= dvs_next;
        rem_reg     <= rem_next;
        oi_reg      <= oi_next;
        first_reg   <= first_next;
        prev_reg    <= prev_next;
        p_reg       <= p_next;
        saved_reg   <= saved_next;
        t_reg       <= t_next;
        steps_reg   <= steps_next;
        power_reg   <= power_next;
        lam_reg     <= lam_next;
        mode_reg    <= mode_next;
        out_idx_reg <= out_idx_next;
        out_bad_reg <= out_bad_next;
    end

    assign s_tready = (state_reg == S_IDLE);
    assign m_tvalid = (state_reg == S_OUT);
    assign m_tdata  = rcbc_pkg::OUT_DATA_W'(out_idx_reg);
    assign m_tuser  = out_bad_reg;

endmodule

@@ src/rcbc_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
module rcbc_ram #(
    parameter int WIDTH = 10,
    parameter int DEPTH = 1024
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

@@ src/rcbc_checker.sv @@
// Port-level checker for the random cycle builder, bound to the top level.
`include "random_cycle_builder_and_chaser_assert.svh"

module rcbc_checker (
    input logic                            aclk,
    input logic                            aresetn,
    input logic                            s_tvalid,
    input logic                            s_tready,
    input logic [rcbc_pkg::IN_DATA_W-1:0]  s_tdata,
    input logic                            s_tuser,
    input logic                            m_tvalid,
    input logic                            m_tready,
    input logic [rcbc_pkg::OUT_DATA_W-1:0] m_tdata,
    input logic                            m_tuser
);

    logic build_req;
    assign build_req = s_tvalid && s_tready && (s_tuser == rcbc_pkg::MODE_BUILD);

    `RCBC_ASSERT_NEXT(a_out_hold, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata))
    `RCBC_ASSERT_NOW(a_one_at_a_time, m_tvalid, !s_tready)
    `RCBC_ASSERT_NEXT(a_busy_after_req, s_tvalid && s_tready, !s_tready)
    `RCBC_ASSERT_NEXT(a_build_busy, build_req, !m_tvalid)
    `RCBC_ASSERT_NOW(a_pad_zero, m_tvalid, m_tdata[15:10] == 6'd0)

endmodule

bind random_cycle_builder_and_chaser rcbc_checker u_rcbc_checker (.*);
